[hw/rtl/bqf_pkg.sv]
package bqf_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int COEF_BITS   = 24;
  localparam int PROD_BITS   = SAMPLE_BITS + COEF_BITS;
  // five products of PROD_BITS each, plus headroom
  localparam int ACC_BITS    = PROD_BITS + 3;
  // numerator 2*|acc| + |a0|, denominator 2*|a0|
  localparam int NUM_BITS    = ACC_BITS + 1;
  localparam int DEN_BITS    = COEF_BITS + 1;
  localparam int DIV_CNT_BITS = $clog2(NUM_BITS);

  localparam int CFG_IDX_BITS = 3;
  localparam int TAPS         = 5;
  localparam int TAP_BITS     = $clog2(TAPS);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [COEF_BITS-1:0]   coef_t;
  typedef logic signed [PROD_BITS-1:0]   prod_t;
  typedef logic signed [ACC_BITS-1:0]    acc_t;
  typedef logic [ACC_BITS-1:0]           mag_t;
  typedef logic [NUM_BITS-1:0]           num_t;
  typedef logic [DEN_BITS-1:0]           den_t;
  typedef logic [CFG_IDX_BITS-1:0]       cfg_idx_t;
  typedef logic [TAP_BITS-1:0]           tap_t;

  localparam cfg_idx_t REG_A0 = 3'd0;
  localparam cfg_idx_t REG_A1 = 3'd1;
  localparam cfg_idx_t REG_A2 = 3'd2;
  localparam cfg_idx_t REG_B0 = 3'd3;
  localparam cfg_idx_t REG_B1 = 3'd4;
  localparam cfg_idx_t REG_B2 = 3'd5;

  localparam tap_t TAP_B0 = TAP_BITS'(0);
  localparam tap_t TAP_B1 = TAP_BITS'(1);
  localparam tap_t TAP_B2 = TAP_BITS'(2);
  localparam tap_t TAP_A1 = TAP_BITS'(3);
  localparam tap_t TAP_A2 = TAP_BITS'(4);

  localparam coef_t COEF_ONE = COEF_BITS'(1 << 20);

  localparam sample_t SMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam sample_t SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam num_t    LIM_POS = NUM_BITS'({1'b0, {(SAMPLE_BITS-1){1'b1}}});
  localparam num_t    LIM_NEG = NUM_BITS'({1'b1, {(SAMPLE_BITS-1){1'b0}}});

  typedef struct packed {
    logic clear;
    logic issue;
    logic sub;
  } mac_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

[hw/rtl/bqf_mac.sv]
module bqf_mac (
  input  logic              clk,
  input  logic              rst,
  input  bqf_pkg::mac_ctrl_t ctrl,
  input  bqf_pkg::coef_t    coef,
  input  bqf_pkg::sample_t  sample,
  output bqf_pkg::acc_t     acc
);
  import bqf_pkg::*;

  prod_t prod;
  logic  prod_vld;
  logic  prod_sub;

  // product register, then accumulate from it in the next cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld <= 1'b0;
    end else if (ctrl.clear) begin
      prod_vld <= 1'b0;
    end else begin
      prod_vld <= ctrl.issue;
    end
    prod     <= coef * sample;
    prod_sub <= ctrl.sub;
  end

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      acc <= '0;
    end else if (prod_vld) begin
      if (prod_sub) begin
        acc <= acc - ACC_BITS'(prod);
      end else begin
        acc <= acc + ACC_BITS'(prod);
      end
    end
  end

endmodule

[hw/rtl/bqf_div.sv]
module bqf_div (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  bqf_pkg::num_t        num,
  input  bqf_pkg::den_t        den,
  output bqf_pkg::num_t        quot,
  output bqf_pkg::div_status_t status
);
  import bqf_pkg::*;

  logic [DEN_BITS-1:0]     rem;
  den_t                    den_r;
  logic [DIV_CNT_BITS-1:0] count;
  logic                    busy;
  logic [DEN_BITS:0]       rem_sh;
  logic [DEN_BITS:0]       diff;
  logic                    fits;

  // restoring division, one quotient bit per cycle; quot shifts the
  // numerator out as the quotient bits come in
  always_comb begin
    rem_sh = {rem, quot[NUM_BITS-1]};
    diff   = rem_sh - {1'b0, den_r};
    fits   = !diff[DEN_BITS];
  end

  assign status.busy = busy;
  assign status.done = busy && (count == DIV_CNT_BITS'(NUM_BITS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (status.done) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      den_r <= den;
      quot  <= num;
      count <= '0;
    end else if (busy) begin
      rem   <= fits ? diff[DEN_BITS-1:0] : rem_sh[DEN_BITS-1:0];
      quot  <= {quot[NUM_BITS-2:0], fits};
      count <= count + 1'b1;
    end
  end

endmodule

[hw/rtl/biquad_iir_filter.sv]
// channel   direction  handshake                 payload
// in        sink       in_valid / in_ready       sample_in
// out       source     out_valid / out_ready     sample_out, clipped, zero_divisor
// cfg       sink       cfg_wr_en                 cfg_index, cfg_wr_data
//
// a sample goes from acceptance to result through a multiply-accumulate for each
// of the five taps on the shared multiplier, drain, magnitude setup and divider
// load, the bit-serial divider, and the load of the output register; with a
// zero divisor the divider is skipped
// rst is synchronous, active high; it restores the coefficients and clears
// the history; the output register lets a new sample be taken while the
// last result waits, a finished result waits until the output is free
module biquad_iir_filter (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  bqf_pkg::sample_t          sample_in,
  output logic                      out_valid,
  input  logic                      out_ready,
  output bqf_pkg::sample_t          sample_out,
  output logic                      clipped,
  output logic                      zero_divisor,
  input  logic                      cfg_wr_en,
  input  bqf_pkg::cfg_idx_t         cfg_index,
  input  logic [bqf_pkg::COEF_BITS-1:0] cfg_wr_data
);
  import bqf_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_MAC    = 7'b0000010,
    S_DRAIN  = 7'b0000100,
    S_MAG    = 7'b0001000,
    S_LOAD   = 7'b0010000,
    S_DIV    = 7'b0100000,
    S_FINISH = 7'b1000000
  } state_t;

  state_t state, state_next;

  coef_t   coef_a0, coef_a1, coef_a2, coef_b0, coef_b1, coef_b2;
  sample_t prev_in_1, prev_in_2, prev_out_1, prev_out_2;
  sample_t x;
  tap_t    tap;

  mac_ctrl_t   mac_ctrl;
  coef_t       mac_coef;
  sample_t     mac_sample;
  acc_t        acc;

  mag_t        n_mag;
  logic [COEF_BITS-1:0] d_mag;
  logic        neg;
  logic        zdiv;
  logic        div_start;
  num_t        div_num;
  den_t        div_den;
  num_t        quot;
  div_status_t div_status;

  logic    accept;
  logic    finish;
  logic    clip;
  sample_t y;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign finish   = (state == S_FINISH) && (!out_valid || out_ready);

  // coefficient registers
  always_ff @(posedge clk) begin
    if (rst) begin
      coef_a0 <= COEF_ONE;
      coef_a1 <= '0;
      coef_a2 <= '0;
      coef_b0 <= COEF_ONE;
      coef_b1 <= '0;
      coef_b2 <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_A0:  coef_a0 <= cfg_wr_data;
        REG_A1:  coef_a1 <= cfg_wr_data;
        REG_A2:  coef_a2 <= cfg_wr_data;
        REG_B0:  coef_b0 <= cfg_wr_data;
        REG_B1:  coef_b1 <= cfg_wr_data;
        REG_B2:  coef_b2 <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (accept) state_next = S_MAC;
      S_MAC:    if (tap == TAP_A2) state_next = S_DRAIN;
      S_DRAIN:  state_next = S_MAG;
      S_MAG:    state_next = S_LOAD;
      S_LOAD:   state_next = zdiv ? S_FINISH : S_DIV;
      S_DIV:    if (div_status.done) state_next = S_FINISH;
      S_FINISH: if (finish) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x   <= sample_in;
      tap <= TAP_B0;
    end else if (state == S_MAC) begin
      tap <= tap + 1'b1;
    end
  end

  // operand select for the shared multiplier
  always_comb begin
    mac_ctrl.clear = accept;
    mac_ctrl.issue = (state == S_MAC);
    mac_ctrl.sub   = 1'b0;
    mac_coef       = coef_b0;
    mac_sample     = x;
    unique case (tap)
      TAP_B0: begin
        mac_coef   = coef_b0;
        mac_sample = x;
      end
      TAP_B1: begin
        mac_coef   = coef_b1;
        mac_sample = prev_in_1;
      end
      TAP_B2: begin
        mac_coef   = coef_b2;
        mac_sample = prev_in_2;
      end
      TAP_A1: begin
        mac_coef     = coef_a1;
        mac_sample   = prev_out_1;
        mac_ctrl.sub = 1'b1;
      end
      TAP_A2: begin
        mac_coef     = coef_a2;
        mac_sample   = prev_out_2;
        mac_ctrl.sub = 1'b1;
      end
      default: ;
    endcase
  end

  bqf_mac u_mac (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (mac_ctrl),
    .coef   (mac_coef),
    .sample (mac_sample),
    .acc    (acc)
  );

  // magnitudes and sign of the quotient, then the rounding numerator
  always_ff @(posedge clk) begin
    if (state == S_MAG) begin
      n_mag <= acc[ACC_BITS-1] ? mag_t'(-acc) : mag_t'(acc);
      d_mag <= coef_a0[COEF_BITS-1] ? COEF_BITS'(-coef_a0) : COEF_BITS'(coef_a0);
      neg   <= acc[ACC_BITS-1] ^ coef_a0[COEF_BITS-1];
      zdiv  <= (coef_a0 == '0);
    end
  end

  assign div_start = (state == S_LOAD) && !zdiv;
  assign div_num   = {n_mag, 1'b0} + NUM_BITS'(d_mag);
  assign div_den   = {d_mag, 1'b0};

  bqf_div u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .num    (div_num),
    .den    (div_den),
    .quot   (quot),
    .status (div_status)
  );

  // saturation
  always_comb begin
    clip = 1'b0;
    y    = '0;
    if (!zdiv) begin
      if (neg) begin
        clip = quot > LIM_NEG;
        y    = clip ? SMIN : sample_t'(-quot[SAMPLE_BITS-1:0]);
      end else begin
        clip = quot > LIM_POS;
        y    = clip ? SMAX : sample_t'(quot[SAMPLE_BITS-1:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_in_1  <= '0;
      prev_in_2  <= '0;
      prev_out_1 <= '0;
      prev_out_2 <= '0;
    end else if (finish) begin
      prev_in_2  <= prev_in_1;
      prev_in_1  <= x;
      prev_out_2 <= prev_out_1;
      prev_out_1 <= y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      sample_out   <= y;
      clipped      <= clip;
      zero_divisor <= zdiv;
    end
  end

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ready)
    else $error("input taken again right after a transaction");

  a_zero_divisor_out: assert property (@(posedge clk) disable iff (rst)
    (out_valid && zero_divisor) |-> (sample_out == '0 && !clipped))
    else $error("zero divisor result is not a clean zero");

  a_clip_at_rail: assert property (@(posedge clk) disable iff (rst)
    (out_valid && clipped) |-> (sample_out == SMAX || sample_out == SMIN))
    else $error("clipped result is not at a rail");

  a_div_only_when_running: assert property (@(posedge clk) disable iff (rst)
    div_status.busy |-> (state == S_DIV))
    else $error("divider running outside the divide step");
`endif

endmodule
